[rtl/core/btpc_pkg.sv]
`default_nettype none

package btpc_pkg;

   // sizes of the block
   localparam int NUM_SLOTS   = 4;
   localparam int TIMEOUT_MS  = 15;
   localparam int SLOT_W      = 13;
   localparam int TABLE_W     = 52;
   localparam int POS_W       = 13;
   localparam int RAW_W       = 12;
   localparam int TIME_W      = 16;
   localparam int PRESET_W    = 4;
   localparam int POWER_W     = 8;
   localparam int LIMIT_W     = 14;
   localparam int SLOTIDX_W   = 3;
   localparam int CSR_INDEX_W = 4;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_STILL_POWER     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_UP_POWER        = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DOWN_POWER      = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT_LOW       = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT_HIGH      = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SENSOR_REVERSED = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SENSOR_PRESENT  = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_TABLE    = 4'd7;

   // fixed codes and values
   localparam logic [SLOT_W-1:0]    EMPTY_MARK     = 13'h1FFF;
   localparam logic [SLOTIDX_W-1:0] SLOT_NONE      = 3'b111;
   localparam logic [POWER_W-1:0]   POWER_FULL_POS = 8'sd127;
   localparam logic [POWER_W-1:0]   POWER_FULL_NEG = -8'sd127;
   localparam logic [POWER_W-1:0]   POWER_ZERO     = 8'd0;
   localparam logic [POS_W-1:0]     POS_FULL_SCALE = 13'd4096;

   typedef struct packed {
      logic signed [POWER_W-1:0] still_power;
      logic signed [POWER_W-1:0] up_power;
      logic signed [POWER_W-1:0] down_power;
      logic signed [LIMIT_W-1:0] limit_low;
      logic signed [LIMIT_W-1:0] limit_high;
      logic                      sensor_reversed;
      logic                      sensor_present;
      logic [TABLE_W-1:0]        target_table;
   } cfg_type;

   typedef struct packed {
      logic                up_pressed;
      logic                down_pressed;
      logic [PRESET_W-1:0] preset_pressed;
      logic [RAW_W-1:0]    sensor_raw;
      logic [TIME_W-1:0]   now_ms;
   } item_type;

   typedef struct packed {
      logic signed [SLOTIDX_W-1:0] selected_slot;
      logic [POS_W-1:0]            last_position;
      logic [TIME_W-1:0]           timer_start;
   } state_type;

   typedef struct packed {
      logic signed [POWER_W-1:0]   drive_power;
      logic signed [SLOTIDX_W-1:0] slot_active;
   } result_type;

   // one target position out of the packed table
   function automatic logic [SLOT_W-1:0] slot_target(input logic [TABLE_W-1:0] tbl,
                                                     input logic [1:0] idx);
      return tbl[idx*SLOT_W +: SLOT_W];
   endfunction

endpackage

`default_nettype wire

[rtl/core/btpc_csr.sv]
`default_nettype none

module btpc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   input  wire logic [btpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [btpc_pkg::TABLE_W-1:0]     csr_data,
   output      btpc_pkg::cfg_type                cfg
);
   import btpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode one write transaction, unknown indexes leave everything as it is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_STILL_POWER:     cfg_in.still_power     = csr_data[POWER_W-1:0];
            REG_UP_POWER:        cfg_in.up_power        = csr_data[POWER_W-1:0];
            REG_DOWN_POWER:      cfg_in.down_power      = csr_data[POWER_W-1:0];
            REG_LIMIT_LOW:       cfg_in.limit_low       = csr_data[LIMIT_W-1:0];
            REG_LIMIT_HIGH:      cfg_in.limit_high      = csr_data[LIMIT_W-1:0];
            REG_SENSOR_REVERSED: cfg_in.sensor_reversed = csr_data[0];
            REG_SENSOR_PRESENT:  cfg_in.sensor_present  = csr_data[0];
            REG_TARGET_TABLE:    cfg_in.target_table    = csr_data;
            default: ;
         endcase
      end
   end

   // register bank with its reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.still_power     <= POWER_ZERO;
         cfg_ff.up_power        <= POWER_FULL_POS;
         cfg_ff.down_power      <= POWER_FULL_NEG;
         cfg_ff.limit_low       <= -14'sd1;
         cfg_ff.limit_high      <= 14'sd4097;
         cfg_ff.sensor_reversed <= 1'b0;
         cfg_ff.sensor_present  <= 1'b0;
         cfg_ff.target_table    <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/core/btpc_step.sv]
`default_nettype none

module btpc_step (
   input  wire btpc_pkg::cfg_type    cfg,
   input  wire btpc_pkg::item_type   item,
   input  wire btpc_pkg::state_type  state,
   output btpc_pkg::state_type       state_next,
   output btpc_pkg::result_type      result
);
   import btpc_pkg::*;

   logic [POS_W-1:0]          pos;
   logic                      hit;
   logic [1:0]                hit_idx;
   logic                      stop;
   logic signed [SLOTIDX_W-1:0] sel;
   logic [POS_W-1:0]          last_pos;
   logic [SLOT_W-1:0]         tgt;
   logic                      last_above;
   logic                      last_equal;
   logic                      pos_above;
   logic                      pos_equal;
   logic [TIME_W-1:0]         elapsed;
   logic signed [POWER_W-1:0] power;
   logic signed [LIMIT_W:0]   pos_s;
   logic                      below_low;
   logic                      above_high;

   // position from the potentiometer reading
   always_comb begin
      if (!cfg.sensor_present) begin
         pos = '0;
      end else if (cfg.sensor_reversed) begin
         pos = POS_FULL_SCALE - {1'b0, item.sensor_raw};
      end else begin
         pos = {1'b0, item.sensor_raw};
      end
   end

   // preset scan, stops at the first empty slot, highest pressed one wins
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      stop    = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!stop) begin
            if (slot_target(cfg.target_table, 2'(i)) == EMPTY_MARK) begin
               stop = 1'b1;
            end else if (item.preset_pressed[i]) begin
               hit     = 1'b1;
               hit_idx = 2'(i);
            end
         end
      end
   end

   // selected slot and position snapshot after the scan
   assign sel      = hit ? $signed({1'b0, hit_idx}) : state.selected_slot;
   assign last_pos = hit ? pos : state.last_position;
   assign tgt      = slot_target(cfg.target_table, sel[1:0]);

   // three-way compares against the target
   assign last_above = last_pos > tgt;
   assign last_equal = last_pos == tgt;
   assign pos_above  = pos > tgt;
   assign pos_equal  = pos == tgt;
   assign elapsed    = item.now_ms - (hit ? item.now_ms : state.timer_start);

   // power selection and state update
   always_comb begin
      state_next = state;
      power      = cfg.still_power;
      priority if (item.up_pressed) begin
         power                    = cfg.up_power;
         state_next.selected_slot = SLOT_NONE;
      end else if (item.down_pressed) begin
         power                    = cfg.down_power;
         state_next.selected_slot = SLOT_NONE;
      end else if (sel[SLOTIDX_W-1]) begin
         power                    = cfg.still_power;
         state_next.selected_slot = SLOT_NONE;
         if (hit) begin
            state_next.last_position = last_pos;
            state_next.timer_start   = item.now_ms;
         end
      end else begin
         state_next.selected_slot = sel;
         state_next.last_position = last_pos;
         state_next.timer_start   = hit ? item.now_ms : state.timer_start;
         power                    = POWER_ZERO;
         if ((last_above == pos_above) && (last_equal == pos_equal)) begin
            // same side of the target, keep driving
            power                    = pos_above ? POWER_FULL_NEG : POWER_FULL_POS;
            state_next.last_position = pos;
            state_next.timer_start   = item.now_ms;
         end else if (elapsed > TIME_W'(TIMEOUT_MS)) begin
            state_next.selected_slot = SLOT_NONE;
         end
      end
   end

   // soft limits
   assign pos_s      = $signed({2'b00, pos});
   assign below_low  = pos_s < $signed({cfg.limit_low[LIMIT_W-1], cfg.limit_low});
   assign above_high = pos_s > $signed({cfg.limit_high[LIMIT_W-1], cfg.limit_high});

   always_comb begin
      result.slot_active = state_next.selected_slot;
      if ((below_low && power < 0) || (above_high && power > 0)) begin
         result.drive_power = cfg.still_power;
      end else begin
         result.drive_power = power;
      end
   end

endmodule

`default_nettype wire

[rtl/core/button_target_position_control_unit.sv]
// Button target position control unit
//
// Input stream req_*: one sensor sample per transaction, carrying the up and
// down buttons, four preset buttons, the raw potentiometer reading and a
// millisecond time stamp. Output stream rsp_*: one transaction per sample
// with the motor power and the slot selected after that sample.
// Configuration port csr_*: one register write per transaction, csr_ready is
// always high; write only while no sample is in flight.
//
// Path: an accepted sample waits in the input register until the result
// register takes it, while that register is empty or its transaction is
// being taken. Throughput: one sample per cycle while the receiver does
// not stall, the selected slot, position snapshot and timer being updated
// combinationally between the two registers.
//
// Reset clears the configuration to its defaults, drops any selected target
// and empties both registers. When the receiver stalls, the result register
// holds its transaction, the input register holds the next sample, and
// req_tready falls once both are full.

`default_nettype none

module button_target_position_control_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // fields from bit 0: up_pressed, down_pressed, preset_pressed[3:0],
   // sensor_raw[11:0], now_ms[15:0], zero padding
   input  wire logic [btpc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // fields from bit 0: drive_power[7:0], slot_active[2:0], zero padding
   output      logic [btpc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [btpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [btpc_pkg::TABLE_W-1:0]     csr_data
);
   import btpc_pkg::*;

   cfg_type    cfg;
   item_type   s1_item_ff;
   item_type   s1_item_in;
   logic       s1_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type step_result;
   result_type out_ff;
   logic       out_valid_ff;
   logic       advance;
   logic       req_take;

   // configuration registers
   assign csr_ready = 1'b1;

   btpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // handshake control
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // unpack the input transaction
   assign s1_item_in.up_pressed     = req_tdata[0];
   assign s1_item_in.down_pressed   = req_tdata[1];
   assign s1_item_in.preset_pressed = req_tdata[5:2];
   assign s1_item_in.sensor_raw     = req_tdata[17:6];
   assign s1_item_in.now_ms         = req_tdata[33:18];

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_take) begin
         s1_item_ff <= s1_item_in;
      end
   end

   // per-sample control step
   btpc_step u_step (
      .cfg        (cfg),
      .item       (s1_item_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   // target state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.selected_slot <= SLOT_NONE;
         state_ff.last_position <= '0;
         state_ff.timer_start   <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - POWER_W - SLOTIDX_W){1'b0}},
                        out_ff.slot_active, out_ff.drive_power};

endmodule

`default_nettype wire

[rtl/core/btpc_checker.sv]
`default_nettype none

module btpc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic [btpc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic                             csr_ready
);
   import btpc_pkg::*;

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // slot field is none or a real slot
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:8] != 3'd4) && (rsp_tdata[10:8] != 3'd5)
                     && (rsp_tdata[10:8] != 3'd6))
      else $error("slot out of range");

   // padding stays zero and configuration never stalls
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:POWER_W+SLOTIDX_W] == '0) && csr_ready)
      else $error("padding set or configuration stalled");

endmodule

bind button_target_position_control_unit btpc_checker u_btpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .csr_ready  (csr_ready)
);

`default_nettype wire

[verif/tb_button_target_position_control_unit.sv]
`default_nettype none

module tb_button_target_position_control_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import btpc_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 1050;
   localparam int PHASE_ITEMS   = 50;
   localparam int NUM_REGS      = 8;
   localparam int FULL_SCALE    = 4096;
   localparam int RAW_MAX       = 4095;
   localparam int POWER_MAX     = 127;
   localparam int NO_IDLE_FIRST = 300;
   localparam int NO_IDLE_LAST  = 500;
   localparam int REQ_FIELDS_W  = 2 + PRESET_W + RAW_W + TIME_W;

   // index outside the register map, must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 4'd9;

   // one row of the directed table: a register write or a sample
   typedef struct {
      bit                     is_write;
      logic [CSR_INDEX_W-1:0] index;
      logic [TABLE_W-1:0]     data;
      item_type               req_item;
      bit                     typed;
      result_type             want;
   } step_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [TABLE_W-1:0]     csr_data   = '0;

   // predictor copy of registers and control state
   cfg_type    motor_cfg;
   state_type  motor_state;
   result_type expected_powers[$];
   step_type   directed_steps[$];

   int         mismatches   = 0;
   int         stall_cycles = 0;
   int         samples_sent = 0;
   bit         no_idle      = 1'b0;
   int         sensor_walk  = 2048;
   logic [TIME_W-1:0] clock_ms = 16'd1000;

   button_target_position_control_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // motor power and selected slot for one sample, updates the control state
   function automatic result_type predict_motor_power(input item_type s);
      int                pos;
      int                pwr;
      int                sel;
      int                tgt;
      int                last;
      bit                scan_done;
      logic [SLOT_W-1:0] slot_pos;
      logic [TIME_W-1:0] elapsed;
      result_type        r;
      // position from the potentiometer
      if (!motor_cfg.sensor_present) begin
         pos = 0;
      end else if (motor_cfg.sensor_reversed) begin
         pos = FULL_SCALE - int'(s.sensor_raw);
      end else begin
         pos = int'(s.sensor_raw);
      end
      sel = $signed(motor_state.selected_slot);
      pwr = 0;
      if (s.up_pressed) begin
         pwr = $signed(motor_cfg.up_power);
         sel = -1;
      end else if (s.down_pressed) begin
         pwr = $signed(motor_cfg.down_power);
         sel = -1;
      end else begin
         // preset scan up to the first empty slot, highest pressed wins
         scan_done = 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_pos = SLOT_W'(motor_cfg.target_table >> (i * SLOT_W));
            if (slot_pos == EMPTY_MARK) scan_done = 1'b1;
            if (!scan_done && s.preset_pressed[i]) begin
               motor_state.timer_start   = s.now_ms;
               motor_state.last_position = pos[POS_W-1:0];
               sel = i;
            end
         end
         if (sel < 0) begin
            sel = -1;
            pwr = $signed(motor_cfg.still_power);
         end else begin
            // full power toward the target while still on the same side
            slot_pos = SLOT_W'(motor_cfg.target_table >> (sel * SLOT_W));
            tgt  = int'(slot_pos);
            last = int'(motor_state.last_position);
            if ((last > tgt) == (pos > tgt) && (last < tgt) == (pos < tgt)) begin
               pwr = (pos > tgt) ? -POWER_MAX : POWER_MAX;
               motor_state.last_position = pos[POS_W-1:0];
               motor_state.timer_start   = s.now_ms;
            end else begin
               elapsed = s.now_ms - motor_state.timer_start;
               if (elapsed > TIMEOUT_MS) sel = -1;
            end
         end
      end
      // soft limits
      if ((pos < $signed(motor_cfg.limit_low) && pwr < 0) ||
          (pos > $signed(motor_cfg.limit_high) && pwr > 0)) begin
         pwr = $signed(motor_cfg.still_power);
      end
      motor_state.selected_slot = sel[SLOTIDX_W-1:0];
      r.drive_power = pwr[POWER_W-1:0];
      r.slot_active = sel[SLOTIDX_W-1:0];
      return r;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] index,
                                     input logic [TABLE_W-1:0] data);
      case (index)
         REG_STILL_POWER:     motor_cfg.still_power     = data[POWER_W-1:0];
         REG_UP_POWER:        motor_cfg.up_power        = data[POWER_W-1:0];
         REG_DOWN_POWER:      motor_cfg.down_power      = data[POWER_W-1:0];
         REG_LIMIT_LOW:       motor_cfg.limit_low       = data[LIMIT_W-1:0];
         REG_LIMIT_HIGH:      motor_cfg.limit_high      = data[LIMIT_W-1:0];
         REG_SENSOR_REVERSED: motor_cfg.sensor_reversed = data[0];
         REG_SENSOR_PRESENT:  motor_cfg.sensor_present  = data[0];
         REG_TARGET_TABLE:    motor_cfg.target_table    = data;
         default: ;
      endcase
   endfunction

   // directed table rows
   function automatic step_type reg_step(input logic [CSR_INDEX_W-1:0] index,
                                         input logic [TABLE_W-1:0] data);
      step_type st;
      st = '{default: '0};
      st.is_write = 1'b1;
      st.index    = index;
      st.data     = data;
      return st;
   endfunction

   function automatic step_type sample_step(input bit up, input bit dn,
                                            input logic [PRESET_W-1:0] pr,
                                            input logic [RAW_W-1:0] raw,
                                            input logic [TIME_W-1:0] t);
      step_type st;
      st = '{default: '0};
      st.req_item.up_pressed     = up;
      st.req_item.down_pressed   = dn;
      st.req_item.preset_pressed = pr;
      st.req_item.sensor_raw     = raw;
      st.req_item.now_ms         = t;
      return st;
   endfunction

   function automatic step_type checked_step(input bit up, input bit dn,
                                             input logic [PRESET_W-1:0] pr,
                                             input logic [RAW_W-1:0] raw,
                                             input logic [TIME_W-1:0] t,
                                             input logic [POWER_W-1:0] pw,
                                             input logic [SLOTIDX_W-1:0] sl);
      step_type st;
      st = sample_step(up, dn, pr, raw, t);
      st.typed            = 1'b1;
      st.want.drive_power = pw;
      st.want.slot_active = sl;
      return st;
   endfunction

   // one sample transaction, with random gaps ahead of it outside the no-idle window
   task automatic send_sample(input item_type s, input bit typed, input result_type want);
      result_type got;
      no_idle = (samples_sent >= NO_IDLE_FIRST && samples_sent < NO_IDLE_LAST);
      while (!no_idle && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {{(REQ_DATA_W-REQ_FIELDS_W){1'b0}}, s.now_ms, s.sensor_raw,
                     s.preset_pressed, s.down_pressed, s.up_pressed};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      got = predict_motor_power(s);
      expected_powers.push_back(typed ? want : got);
      samples_sent++;
   endtask

   // register write, only once the block has drained
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [TABLE_W-1:0] data);
      req_tvalid <= 1'b0;
      while (expected_powers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_index <= index;
      csr_data  <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(index, data);
      csr_valid <= 1'b0;
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 30);
      end
   end

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.drive_power = rsp_tdata[POWER_W-1:0];
         seen.slot_active = rsp_tdata[POWER_W +: SLOTIDX_W];
         if (expected_powers.size() == 0) begin
            $error("unexpected result: drive_power %0d slot_active %0d",
                   seen.drive_power, seen.slot_active);
            mismatches++;
         end else begin
            want = expected_powers.pop_front();
            if (seen.drive_power !== want.drive_power) begin
               $error("drive_power: expected %0d, got %0d",
                      want.drive_power, seen.drive_power);
               mismatches++;
            end
            if (seen.slot_active !== want.slot_active) begin
               $error("slot_active: expected %0d, got %0d",
                      want.slot_active, seen.slot_active);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      item_type           s;
      result_type         no_result;
      logic [TABLE_W-1:0] value;
      logic [SLOT_W-1:0]  slot_pos;
      int                 left;
      int                 span;
      int                 slot;
      int                 goal;
      int                 dir;
      int                 low_mask;
      int                 roll;
      int                 random_done;

      // register and state defaults after reset
      motor_cfg.still_power     = 8'sd0;
      motor_cfg.up_power        = 8'sd127;
      motor_cfg.down_power      = -8'sd127;
      motor_cfg.limit_low       = -14'sd1;
      motor_cfg.limit_high      = 14'sd4097;
      motor_cfg.sensor_reversed = 1'b0;
      motor_cfg.sensor_present  = 1'b0;
      motor_cfg.target_table    = '1;
      motor_state.selected_slot = SLOT_NONE;
      motor_state.last_position = '0;
      motor_state.timer_start   = '0;
      no_result = '0;

      // buttons at reset defaults, no sensor, empty table
      directed_steps.push_back(checked_step(1, 0, 4'h0, 12'h000, 16'h0000, 8'sd127, SLOT_NONE));
      directed_steps.push_back(checked_step(0, 1, 4'hF, 12'hFFF, 16'hFFFF, -8'sd127, SLOT_NONE));
      directed_steps.push_back(checked_step(1, 1, 4'hF, 12'hFFF, 16'hFFFF, 8'sd127, SLOT_NONE));
      directed_steps.push_back(checked_step(0, 0, 4'hF, 12'h800, 16'h1234, 8'sd0, SLOT_NONE));
      // slot 2 empty hides slot 3
      directed_steps.push_back(reg_step(REG_SENSOR_PRESENT, 52'd1));
      directed_steps.push_back(reg_step(REG_TARGET_TABLE,
                                        {13'd2000, EMPTY_MARK, 13'd3000, 13'd1000}));
      // approach, cross, then time out
      directed_steps.push_back(sample_step(0, 0, 4'b1011, 12'd500, 16'd100));
      directed_steps.push_back(sample_step(0, 0, 4'b0000, 12'd2999, 16'd110));
      directed_steps.push_back(sample_step(0, 0, 4'b0000, 12'd3001, 16'd120));
      directed_steps.push_back(sample_step(0, 0, 4'b0000, 12'd3001, 16'd126));
      // sitting exactly on the target
      directed_steps.push_back(sample_step(0, 0, 4'b0001, 12'd1000, 16'd200));
      directed_steps.push_back(sample_step(0, 0, 4'b0000, 12'd1000, 16'd205));
      // timer wrap around zero
      directed_steps.push_back(sample_step(0, 0, 4'b0001, 12'd0, 16'd65530));
      directed_steps.push_back(sample_step(0, 0, 4'b0000, 12'd2000, 16'd5));
      directed_steps.push_back(sample_step(0, 0, 4'b0000, 12'd2000, 16'd10));
      // target below, then up cancels it
      directed_steps.push_back(sample_step(0, 0, 4'b0001, 12'd3000, 16'd20));
      directed_steps.push_back(sample_step(1, 0, 4'b0001, 12'd3000, 16'd21));
      // reversed sensor, high limit, extreme powers
      directed_steps.push_back(reg_step(REG_SENSOR_REVERSED, 52'd1));
      directed_steps.push_back(reg_step(REG_LIMIT_HIGH, 52'd4000));
      directed_steps.push_back(reg_step(REG_STILL_POWER, 52'h0FB));
      directed_steps.push_back(reg_step(REG_UP_POWER, 52'h080));
      directed_steps.push_back(reg_step(REG_DOWN_POWER, 52'h07F));
      directed_steps.push_back(sample_step(0, 0, 4'b0001, 12'd0, 16'd30));
      directed_steps.push_back(sample_step(0, 1, 4'b0000, 12'd0, 16'd31));
      directed_steps.push_back(sample_step(1, 0, 4'b0000, 12'd4095, 16'd32));
      // limits that block everything, sensor gone
      directed_steps.push_back(reg_step(REG_LIMIT_LOW, 52'd4097));
      directed_steps.push_back(reg_step(REG_LIMIT_HIGH, 52'h3FFF));
      directed_steps.push_back(reg_step(REG_SENSOR_PRESENT, 52'd0));
      directed_steps.push_back(sample_step(0, 0, 4'b0000, 12'd1234, 16'd40));
      directed_steps.push_back(sample_step(0, 0, 4'b0010, 12'd0, 16'd41));
      // selected slot emptied by a table rewrite
      directed_steps.push_back(reg_step(REG_SENSOR_PRESENT, 52'd1));
      directed_steps.push_back(reg_step(REG_SENSOR_REVERSED, 52'd0));
      directed_steps.push_back(reg_step(REG_LIMIT_LOW, 52'h3FFF));
      directed_steps.push_back(reg_step(REG_LIMIT_HIGH, 52'd4097));
      directed_steps.push_back(reg_step(REG_STILL_POWER, 52'd0));
      directed_steps.push_back(reg_step(REG_TARGET_TABLE,
                                        {13'd2000, 13'd500, EMPTY_MARK, 13'd1000}));
      directed_steps.push_back(sample_step(0, 0, 4'b0000, 12'd100, 16'd50));
      // write outside the map changes nothing
      directed_steps.push_back(reg_step(REG_SPARE, '1));
      directed_steps.push_back(sample_step(0, 0, 4'b0001, 12'd100, 16'd51));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[k]) begin
         if (directed_steps[k].is_write) begin
            write_reg(directed_steps[k].index, directed_steps[k].data);
         end else begin
            send_sample(directed_steps[k].req_item, directed_steps[k].typed,
                        directed_steps[k].want);
         end
      end

      // random phases: new register settings, then approach runs and noise
      random_done = 0;
      while (random_done < RANDOM_ITEMS) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            if ($urandom_range(99) < 40) begin
               value = TABLE_W'({$urandom, $urandom});
               roll  = $urandom_range(0, 9);
               case (r)
                  REG_STILL_POWER, REG_UP_POWER, REG_DOWN_POWER: begin
                     case (roll)
                        0: value[POWER_W-1:0] = 8'h81;
                        1: value[POWER_W-1:0] = 8'h7F;
                        2: value[POWER_W-1:0] = 8'h80;
                        3: value[POWER_W-1:0] = 8'h00;
                        default: value[POWER_W-1:0] =
                           POWER_W'(int'($urandom_range(0, 254)) - POWER_MAX);
                     endcase
                  end
                  REG_LIMIT_LOW, REG_LIMIT_HIGH: begin
                     case (roll)
                        0: value[LIMIT_W-1:0] = 14'h3FFF;
                        1: value[LIMIT_W-1:0] = 14'd4097;
                        2: value[LIMIT_W-1:0] = 14'h2000;
                        3: value[LIMIT_W-1:0] = 14'h1FFF;
                        4: value[LIMIT_W-1:0] = 14'd0;
                        5: value[LIMIT_W-1:0] = 14'd4096;
                        default: value[LIMIT_W-1:0] =
                           LIMIT_W'(int'($urandom_range(0, 4098)) - 1);
                     endcase
                  end
                  REG_SENSOR_PRESENT: begin
                     value[0] = (roll < 8);
                  end
                  REG_TARGET_TABLE: begin
                     for (int j = 0; j < NUM_SLOTS; j++) begin
                        roll = $urandom_range(0, 19);
                        if (roll < 3) slot_pos = EMPTY_MARK;
                        else if (roll == 3) slot_pos = '0;
                        else if (roll == 4) slot_pos = 13'd4096;
                        else if (roll == 5) slot_pos = SLOT_W'($urandom);
                        else slot_pos = SLOT_W'($urandom_range(0, FULL_SCALE));
                        value[j*SLOT_W +: SLOT_W] = slot_pos;
                     end
                  end
                  default: ;
               endcase
               write_reg(CSR_INDEX_W'(r), value);
            end
         end
         if ($urandom_range(99) < 10) write_reg(REG_SPARE, TABLE_W'({$urandom, $urandom}));

         left = PHASE_ITEMS;
         while (left > 0) begin
            if ($urandom_range(99) < 25) begin
               // noise: every field at random
               s.up_pressed     = 1'($urandom_range(0, 1));
               s.down_pressed   = 1'($urandom_range(0, 1));
               s.preset_pressed = PRESET_W'($urandom_range(0, 15));
               s.sensor_raw     = RAW_W'($urandom_range(0, RAW_MAX));
               s.now_ms         = TIME_W'($urandom_range(0, 65535));
               send_sample(s, 1'b0, no_result);
               sensor_walk = int'(s.sensor_raw);
               clock_ms    = s.now_ms;
               left--;
            end else begin
               // run toward one preset target, past it and into the timeout
               slot     = $urandom_range(0, NUM_SLOTS - 1);
               slot_pos = SLOT_W'(motor_cfg.target_table >> (slot * SLOT_W));
               goal     = motor_cfg.sensor_reversed ? FULL_SCALE - int'(slot_pos)
                                                    : int'(slot_pos);
               if (goal > RAW_MAX) goal = RAW_MAX;
               if (goal < 0) goal = 0;
               dir      = (goal >= sensor_walk) ? 1 : -1;
               low_mask = (1 << slot) - 1;
               span     = $urandom_range(4, 24);
               for (int n = 0; n < span && left > 0; n++) begin
                  s.up_pressed   = ($urandom_range(99) < 4);
                  s.down_pressed = ($urandom_range(99) < 4);
                  if (n == 0 && $urandom_range(99) < 90) begin
                     s.preset_pressed =
                        PRESET_W'((1 << slot) | (int'($urandom_range(0, 15)) & low_mask));
                  end else if ($urandom_range(99) < 8) begin
                     s.preset_pressed = PRESET_W'($urandom_range(0, 15));
                  end else begin
                     s.preset_pressed = '0;
                  end
                  if ($urandom_range(99) < 10) sensor_walk = goal;
                  else sensor_walk = sensor_walk + dir * int'($urandom_range(0, 300));
                  if (sensor_walk > RAW_MAX) sensor_walk = RAW_MAX;
                  if (sensor_walk < 0) sensor_walk = 0;
                  clock_ms     = TIME_W'(clock_ms + $urandom_range(0, 7));
                  s.sensor_raw = RAW_W'(sensor_walk);
                  s.now_ms     = clock_ms;
                  send_sample(s, 1'b0, no_result);
                  left--;
               end
            end
         end
         random_done += PHASE_ITEMS;
      end

      // drain, then allow for stray results
      req_tvalid <= 1'b0;
      while (expected_powers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_powers.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
